FILE: rtl/core/dcsr_pkg.sv
// ----------------------------------------------------------------------------
// Divisor count and sum ratio: shared package
// Widths, codes and the types passed between the front end, the queue and
// the sequencer of the divisor count and sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcsr_pkg;

	localparam int NUM_W       = 17;
	localparam int D_W         = 10;
	localparam int DD_W        = 2 * D_W;
	localparam int EXP_W       = 5;
	localparam int TAU_W       = 8;
	localparam int SIG_W       = 24;
	localparam int GS_W        = NUM_W + 1;
	localparam int CNT_W       = 5;
	localparam int MAX_FACTORS = 8;
	localparam int MANT_BITS   = 53;
	localparam int QUO_W       = MANT_BITS;
	localparam int M_W         = MANT_BITS + 1;
	localparam int V_W         = M_W + 7;
	localparam int DVS_W       = D_W;
	localparam int REM_W       = DVS_W;
	localparam int STP_W       = 5;
	localparam int NB_W        = 6;
	localparam int SUM_OUT_W   = 20;
	localparam int RAT_W       = 23;
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_AW     = 1;
	localparam int FIFO_CW     = 2;

	localparam logic [SIG_W-1:0] SIG_OUT_MAX = SIG_W'(20'hFFFFF);
	localparam logic [V_W-1:0]   RATIO_MAX   = V_W'(23'h7FFFFF);
	localparam logic [RAT_W-1:0] RATIO_ONE   = RAT_W'(100);

	localparam logic KIND_FACTOR  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_ONE,
		CLS_GEN
	} cls_t;

	typedef struct packed {
		cls_t             cls;
		logic [NUM_W-1:0] num;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_CHK,
		ST_FACT,
		ST_REMN,
		ST_RSTART,
		ST_RDIV,
		ST_RRND,
		ST_RMUL1,
		ST_RMUL2,
		ST_RFIN,
		ST_SUMM
	} state_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [SIG_W-1:0] dvd;
		logic [DVS_W-1:0] dvs;
	} div_ctl_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic             qbit;
	} div_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/dcsr_div.sv
// ----------------------------------------------------------------------------
// Divisor count and sum ratio: serial divider
// Restoring divider that yields one quotient bit a cycle while stepped, shared
// by the trial divisions and the long division for the ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsr_div (
	input  wire logic               clk,
	input  wire dcsr_pkg::div_ctl_t ctl,
	output dcsr_pkg::div_sts_t      sts
);
	import dcsr_pkg::*;

	logic [SIG_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [REM_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [REM_W:0]   trial;
	logic [REM_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[SIG_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvd_q <= ctl.dvd;
			dvs_q <= ctl.dvs;
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctl.step) begin
			dvd_q <= {dvd_q[SIG_W-2:0], 1'b0};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign sts.rem  = rem_q;
	assign sts.quo  = quo_q;
	assign sts.qbit = ge;

endmodule

`default_nettype wire

FILE: rtl/core/dcsr_front.sv
// ----------------------------------------------------------------------------
// Divisor count and sum ratio: front end
// Accepts input words, classifies them as zero, one or general and holds
// them in a register until the queue takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsr_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [dcsr_pkg::NUM_W-1:0] number,
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output dcsr_pkg::item_t                 push_item
);
	import dcsr_pkg::*;

	logic  valid_q;
	item_t item_q;
	cls_t  cls;

	always_comb begin
		if (number == '0) begin
			cls = CLS_ZERO;
		end else if (number == NUM_W'(1)) begin
			cls = CLS_ONE;
		end else begin
			cls = CLS_GEN;
		end
	end

	assign in_ready = !valid_q || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q.cls <= cls;
			item_q.num <= number;
		end
	end

	assign push_valid = valid_q;
	assign push_item  = item_q;

endmodule

`default_nettype wire

FILE: rtl/core/dcsr_fifo.sv
// ----------------------------------------------------------------------------
// Divisor count and sum ratio: item queue
// Two-entry queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsr_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire dcsr_pkg::item_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop,
	output dcsr_pkg::item_t      pop_item
);
	import dcsr_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = cnt_q != FIFO_CW'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + FIFO_CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - FIFO_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/dcsr_back.sv
// ----------------------------------------------------------------------------
// Divisor count and sum ratio: sequencer
// Factors each queued number above one by trial division, accumulates tau
// and sigma, forms the rounded ratio and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsr_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pop_valid,
	output logic                                 pop,
	input  wire dcsr_pkg::item_t                 pop_item,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 kind,
	output logic [dcsr_pkg::NUM_W-1:0]           prime,
	output logic [dcsr_pkg::EXP_W-1:0]           exponent,
	output logic [dcsr_pkg::TAU_W-1:0]           divisor_count,
	output logic [dcsr_pkg::SUM_OUT_W-1:0]       divisor_sum,
	output logic [dcsr_pkg::RAT_W-1:0]           ratio_times_100
);
	import dcsr_pkg::*;

	state_t state_q, state_d;

	logic [NUM_W-1:0] x_q;
	logic [D_W-1:0]   d_q;
	logic [EXP_W-1:0] e_q;
	logic [NUM_W-1:0] pw_q;
	logic [GS_W-1:0]  gs_q;
	logic [TAU_W-1:0] tau_q;
	logic [SIG_W-1:0] sig_q;
	logic [CNT_W-1:0] cnt_q;
	logic [STP_W-1:0] stp_q;
	logic [NB_W-1:0]  nb_q;
	logic [NB_W-1:0]  s_q;
	logic             ph_q;
	logic [M_W-1:0]   m_q;
	logic [V_W-1:0]   a_q;
	logic [V_W-1:0]   v_q;
	logic [RAT_W-1:0] rat_q;

	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [NUM_W-1:0]     out_prime_q;
	logic [EXP_W-1:0]     out_exp_q;
	logic [TAU_W-1:0]     out_tau_q;
	logic [SUM_OUT_W-1:0] out_sig_q;
	logic [RAT_W-1:0]     out_rat_q;

	div_ctl_t div_ctl;
	div_sts_t div_sts;

	logic                     out_free;
	logic                     room;
	logic [DD_W-1:0]          dd;
	logic                     test_go;
	logic [D_W-1:0]           d_next;
	logic [NUM_W+D_W-1:0]     pw_prod;
	logic [NUM_W-1:0]         pw_next;
	logic [SIG_W+GS_W-1:0]    sig_gs;
	logic [TAU_W+EXP_W-1:0]   tau_e;
	logic [SIG_W+GS_W-1:0]    sig_x;
	logic                     rem_zero;
	logic                     x_gt1;
	logic                     rdiv_step;
	logic                     rnd_up;
	logic [V_W-1:0]           shifted;
	logic [V_W-1:0]           shifted_m1;
	logic [V_W-1:0]           low_mask;
	logic                     sticky;
	logic [V_W-1:0]           res;
	logic [SIG_W-1:0]         sig_sat;
	logic                     ld_fact;
	logic                     ld_remn;
	logic                     ld_summ;

	dcsr_div u_div (
		.clk (clk),
		.ctl (div_ctl),
		.sts (div_sts)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign room      = cnt_q < CNT_W'(MAX_FACTORS);
	assign dd        = d_q * d_q;
	assign test_go   = (dd <= DD_W'(x_q)) || (d_q == D_W'(2) && !x_q[0]);
	assign d_next    = (d_q == D_W'(2)) ? D_W'(3) : d_q + D_W'(2);
	assign pw_prod   = pw_q * d_q;
	assign pw_next   = pw_prod[NUM_W-1:0];
	assign sig_gs    = sig_q * gs_q;
	assign tau_e     = tau_q * (e_q + EXP_W'(1));
	assign sig_x     = sig_q * (GS_W'(x_q) + GS_W'(1));
	assign rem_zero  = div_sts.rem == '0;
	assign x_gt1     = x_q > NUM_W'(1);
	assign rdiv_step = !(ph_q && nb_q == NB_W'(MANT_BITS));
	assign rnd_up    = ({1'b0, div_sts.rem, 1'b0} > (REM_W + 2)'(tau_q)) ||
		(({1'b0, div_sts.rem, 1'b0} == (REM_W + 2)'(tau_q)) && div_sts.quo[0]);

	assign shifted    = v_q >> s_q;
	assign shifted_m1 = v_q >> (s_q - NB_W'(1));
	assign low_mask   = (V_W'(1) << (s_q - NB_W'(1))) - V_W'(1);
	assign sticky     = |(v_q & low_mask);
	assign res        = shifted + V_W'(shifted_m1[0] && (sticky || shifted[0]));
	assign sig_sat    = (sig_q > SIG_OUT_MAX) ? SIG_OUT_MAX : sig_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					unique case (pop_item.cls)
						CLS_GEN: state_d = ST_TEST;
						default: state_d = ST_SUMM;
					endcase
				end
			end
			ST_TEST:   state_d = test_go ? ST_DIV : ST_REMN;
			ST_DIV:    state_d = (stp_q == '0) ? ST_CHK : ST_DIV;
			ST_CHK: begin
				if (rem_zero) begin
					state_d = ST_DIV;
				end else if (e_q != '0) begin
					state_d = ST_FACT;
				end else begin
					state_d = ST_TEST;
				end
			end
			ST_FACT:   state_d = (!room || out_free) ? ST_TEST : ST_FACT;
			ST_REMN:   state_d = (x_gt1 && room && !out_free) ? ST_REMN : ST_RSTART;
			ST_RSTART: state_d = ST_RDIV;
			ST_RDIV:   state_d = rdiv_step ? ST_RDIV : ST_RRND;
			ST_RRND:   state_d = ST_RMUL1;
			ST_RMUL1:  state_d = ST_RMUL2;
			ST_RMUL2:  state_d = ST_RFIN;
			ST_RFIN:   state_d = ST_SUMM;
			ST_SUMM:   state_d = out_free ? ST_IDLE : ST_SUMM;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop          = 1'b0;
		div_ctl.load = 1'b0;
		div_ctl.step = 1'b0;
		div_ctl.dvd  = {x_q, (SIG_W - NUM_W)'(0)};
		div_ctl.dvs  = d_q;
		ld_fact      = 1'b0;
		ld_remn      = 1'b0;
		ld_summ      = 1'b0;
		unique case (state_q)
			ST_IDLE:   pop = pop_valid;
			ST_TEST:   div_ctl.load = test_go;
			ST_DIV:    div_ctl.step = 1'b1;
			ST_CHK: begin
				div_ctl.load = rem_zero;
				div_ctl.dvd  = {div_sts.quo[NUM_W-1:0], (SIG_W - NUM_W)'(0)};
			end
			ST_FACT:   ld_fact = room && out_free;
			ST_REMN:   ld_remn = x_gt1 && room && out_free;
			ST_RSTART: begin
				div_ctl.load = 1'b1;
				div_ctl.dvd  = sig_q;
				div_ctl.dvs  = DVS_W'(tau_q);
			end
			ST_RDIV:   div_ctl.step = rdiv_step;
			ST_SUMM:   ld_summ = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_fact || ld_remn || ld_summ) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					x_q   <= pop_item.num;
					d_q   <= D_W'(2);
					e_q   <= '0;
					pw_q  <= NUM_W'(1);
					gs_q  <= GS_W'(1);
					cnt_q <= '0;
					tau_q <= TAU_W'(1);
					sig_q <= SIG_W'(1);
					rat_q <= RATIO_ONE;
					if (pop_item.cls == CLS_ZERO) begin
						tau_q <= '0;
						sig_q <= '0;
						rat_q <= '0;
					end
				end
			end
			ST_TEST: stp_q <= STP_W'(NUM_W - 1);
			ST_DIV:  stp_q <= stp_q - STP_W'(1);
			ST_CHK: begin
				stp_q <= STP_W'(NUM_W - 1);
				if (rem_zero) begin
					x_q  <= div_sts.quo[NUM_W-1:0];
					e_q  <= e_q + EXP_W'(1);
					pw_q <= pw_next;
					gs_q <= gs_q + GS_W'(pw_next);
				end else if (e_q == '0) begin
					d_q <= d_next;
				end
			end
			ST_FACT: begin
				if (!room || out_free) begin
					d_q  <= d_next;
					e_q  <= '0;
					pw_q <= NUM_W'(1);
					gs_q <= GS_W'(1);
				end
				if (ld_fact) begin
					tau_q <= tau_e[TAU_W-1:0];
					sig_q <= sig_gs[SIG_W-1:0];
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_REMN: begin
				if (ld_remn) begin
					tau_q <= {tau_q[TAU_W-2:0], 1'b0};
					sig_q <= sig_x[SIG_W-1:0];
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_RSTART: begin
				stp_q <= STP_W'(SIG_W - 1);
				nb_q  <= '0;
				s_q   <= '0;
				ph_q  <= 1'b0;
			end
			ST_RDIV: begin
				if (rdiv_step) begin
					if (!ph_q) begin
						stp_q <= stp_q - STP_W'(1);
						if (stp_q == '0) begin
							ph_q <= 1'b1;
						end
						if (nb_q != '0 || div_sts.qbit) begin
							nb_q <= nb_q + NB_W'(1);
						end
					end else begin
						nb_q <= nb_q + NB_W'(1);
						s_q  <= s_q + NB_W'(1);
					end
				end
			end
			ST_RRND:  m_q <= M_W'(div_sts.quo) + M_W'(rnd_up);
			ST_RMUL1: a_q <= (V_W'(m_q) << 6) + (V_W'(m_q) << 5);
			ST_RMUL2: v_q <= a_q + (V_W'(m_q) << 2);
			ST_RFIN:  rat_q <= (res > RATIO_MAX) ? RAT_W'(RATIO_MAX) : res[RAT_W-1:0];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_fact || ld_remn) begin
			out_kind_q  <= KIND_FACTOR;
			out_prime_q <= ld_fact ? NUM_W'(d_q) : x_q;
			out_exp_q   <= ld_fact ? e_q : EXP_W'(1);
			out_tau_q   <= '0;
			out_sig_q   <= '0;
			out_rat_q   <= '0;
		end else if (ld_summ) begin
			out_kind_q  <= KIND_SUMMARY;
			out_prime_q <= '0;
			out_exp_q   <= '0;
			out_tau_q   <= tau_q;
			out_sig_q   <= sig_sat[SUM_OUT_W-1:0];
			out_rat_q   <= rat_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_kind_q;
	assign prime           = out_prime_q;
	assign exponent        = out_exp_q;
	assign divisor_count   = out_tau_q;
	assign divisor_sum     = out_sig_q;
	assign ratio_times_100 = out_rat_q;

	a_test_cofactor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEST |-> x_q != '0)
		else $error("Trial division entered with a zero cofactor.");

	a_exp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && rem_zero) |=> e_q == $past(e_q) + EXP_W'(1))
		else $error("Exponent did not advance on an exact division.");

	a_fact_exp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FACT |-> e_q != '0)
		else $error("Factor word with a zero exponent.");

	a_mant_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RDIV |-> nb_q <= NB_W'(MANT_BITS))
		else $error("Ratio mantissa grew beyond its width.");

endmodule

`default_nettype wire

FILE: rtl/core/divisor_count_sum_ratio.sv
// ----------------------------------------------------------------------------
// Divisor count and sum ratio
// Factors each input number by trial division, emits one word per distinct
// prime and a closing summary word with tau, sigma and sigma/tau times 100.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   number
//   out      out_valid / out_ready kind, prime, exponent, divisor_count,
//                                  divisor_sum, ratio_times_100, last
//
// Each trial divisor runs through the serial divider: 2 and then the odd
// divisors up to the square root of the remaining cofactor. The ratio takes
// a further long division in the same divider. The front register and a
// two-entry queue take new numbers while one is being factored. Reset clears
// the state machine, the valid flags and the queue pointers; output stalls
// hold the sequencer at the next word to be written.
// ----------------------------------------------------------------------------
`default_nettype none

module divisor_count_sum_ratio (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [dcsr_pkg::NUM_W-1:0]      number,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 kind,
	output logic [dcsr_pkg::NUM_W-1:0]           prime,
	output logic [dcsr_pkg::EXP_W-1:0]           exponent,
	output logic [dcsr_pkg::TAU_W-1:0]           divisor_count,
	output logic [dcsr_pkg::SUM_OUT_W-1:0]       divisor_sum,
	output logic [dcsr_pkg::RAT_W-1:0]           ratio_times_100,
	output logic                                 last
);
	import dcsr_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop;
	item_t pop_item;

	dcsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.number     (number),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	dcsr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	dcsr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop             (pop),
		.pop_item        (pop_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.prime           (prime),
		.exponent        (exponent),
		.divisor_count   (divisor_count),
		.divisor_sum     (divisor_sum),
		.ratio_times_100 (ratio_times_100)
	);

	assign last = kind == KIND_SUMMARY;

endmodule

`default_nettype wire
